@@ hw/rtl/p2g_pkg.sv @@
// Shared types, constants and the palette quantizer of the palette to 2-bit gray packer.
// Used by palette_to_gray2_pixel_packer and by its port checker.
// Depends on nothing.
package p2g_pkg;

   // Palette geometry.
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int LEVEL_W         = 3;

   localparam logic [LEVEL_W-1:0] TRANSPARENT_CODE = 3'd4;

   // Key colour that is stored as transparent.
   localparam logic [7:0] KEY_BLUE  = 8'd64;
   localparam logic [7:0] KEY_GREEN = 8'd128;
   localparam logic [7:0] KEY_RED   = 8'd128;

   // Luma is (b + 6g + 3r) / 10. Comparing the undivided sum against
   // (threshold + 1) * 10 gives the same decision without a divider.
   localparam int LUMA_DIV  = 10;
   localparam int LUMA_SUMW = 12;
   localparam logic [LUMA_SUMW-1:0] LUMA_T0 = LUMA_SUMW'((8'h2a + 1) * LUMA_DIV);
   localparam logic [LUMA_SUMW-1:0] LUMA_T1 = LUMA_SUMW'((8'h80 + 1) * LUMA_DIV);
   localparam logic [LUMA_SUMW-1:0] LUMA_T2 = LUMA_SUMW'((8'hd4 + 1) * LUMA_DIV);

   // Result planes.
   localparam logic [1:0] PLANE_GRAY    = 2'd0;
   localparam logic [1:0] PLANE_MASK    = 2'd1;
   localparam logic [1:0] PLANE_ONE_BIT = 2'd2;

   // Configuration register indexes.
   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   // Result queue.
   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

   typedef struct packed {
      logic [1:0]  plane;
      logic [15:0] row;
      logic [13:0] byte_index;
      logic [7:0]  value;
      logic        mask_used;
      logic        image_done;
      logic        last;
   } result_type;

   function automatic logic [LEVEL_W-1:0] quantize(input logic [7:0] b,
                                                   input logic [7:0] g,
                                                   input logic [7:0] r);
      logic [LUMA_SUMW-1:0] sum;
      logic [LEVEL_W-1:0]   lv;
      sum = LUMA_SUMW'(b) + (LUMA_SUMW'(g) << 2) + (LUMA_SUMW'(g) << 1)
          + (LUMA_SUMW'(r) << 1) + LUMA_SUMW'(r);
      if (b == KEY_BLUE && g == KEY_GREEN && r == KEY_RED) begin
         lv = TRANSPARENT_CODE;
      end else if (sum < LUMA_T0) begin
         lv = 3'd0;
      end else if (sum < LUMA_T1) begin
         lv = 3'd1;
      end else if (sum < LUMA_T2) begin
         lv = 3'd2;
      end else begin
         lv = 3'd3;
      end
      return lv;
   endfunction

endpackage

@@ hw/rtl/palette_to_gray2_pixel_packer.sv @@
// Palette to 2-bit gray pixel packer: palette memory, packing stage and result queue.
// Depends on p2g_pkg.
//
// The block takes one item per cycle while req_stall is low. A palette write stores the
// quantized gray level of its colour in the palette memory at the edge it is accepted and
// gives no result. A pixel item reads the palette memory at its acceptance edge and is
// packed in the next cycle, so its results are written into the queue at the end of that
// cycle; rsp_valid comes from the registered queue count. An 8-bit pixel gives zero, one
// or two results (gray byte first, then mask byte); a 1-bit data byte gives one. Results
// leave through an eight-entry queue, one per cycle while rsp_stall is low; the input is
// stalled while the queue could not take two results from each item still in flight. With
// a result consumer that does not stall, the input runs at one item per cycle as long as
// items give no more than one result each on average; where every pixel gives two results,
// as in an image one pixel wide, the queue fills and the input is paced by the results.
// Configuration writes are taken on the CSR port at any time but are meant for idle periods.
module palette_to_gray2_pixel_packer (
   input  logic                   clock,
   input  logic                   reset,
   // Input items.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [7:0]             req_palette_index,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_pixel_byte,
   // Result items.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_plane,
   output logic [15:0]            rsp_row,
   output logic [13:0]            rsp_byte_index,
   output logic [7:0]             rsp_value,
   output logic                   rsp_mask_used,
   output logic                   rsp_image_done,
   output logic                   rsp_last,
   // Configuration.
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [p2g_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import p2g_pkg::*;

   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

   // Configuration registers.
   logic        mode_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   // Palette memory and its per-entry valid bits.
   logic [LEVEL_W-1:0]         pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [LEVEL_W-1:0]         pal_rd_ff;
   logic                       pal_rd_vld_ff;
   logic [LEVEL_W-1:0]         lvl0_ff;
   logic [LEVEL_W-1:0]         lvl1_ff;
   logic [LEVEL_W-1:0]         new_level;
   logic                       req_take;
   logic                       pal_wr;
   logic                       pix_take;

   // Packing stage.
   logic        b_vld_ff;
   logic [7:0]  b_pix_ff;
   logic        b_inrange_ff;
   logic [15:0] column_ff, column_in;
   logic [15:0] src_row_ff, src_row_in;
   logic [7:0]  gray_ff, gray_in;
   logic [7:0]  mask_ff, mask_in;
   logic        seen_ff, seen_in;

   logic [LEVEL_W-1:0] lv;
   logic        row_end;
   logic        img_end;
   logic [15:0] out_row;
   logic [16:0] col_next;
   logic        trans;
   logic        seen_now;
   logic [7:0]  gray_new;
   logic [7:0]  mask_new;
   logic        emit_gray;
   logic        emit_mask;
   result_type  res0;
   result_type  res1;
   result_type  gray_res;
   result_type  mask_res;
   logic [1:0]  npush;

   // Result queue.
   result_type          outq [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]  wr_ptr_ff;
   logic [OUTQ_AW-1:0]  rd_ptr_ff;
   logic [OUTQ_AW:0]    count_ff;
   logic                pop;
   logic [OUTQ_AW+1:0]  need;

   // ---------------------------------------------------------------- configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MODE:   mode_ff   <= csr_pwdata[0];
            REG_WIDTH:  width_ff  <= csr_pwdata[15:0];
            REG_HEIGHT: height_ff <= csr_pwdata[15:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MODE:   csr_prdata = {31'd0, mode_ff};
         REG_WIDTH:  csr_prdata = {16'd0, width_ff};
         REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- input and palette
   // Reserve room for two results from the item in the packing stage and two from the
   // item being accepted.
   assign need      = (OUTQ_AW+2)'(count_ff) + (b_vld_ff ? (OUTQ_AW+2)'(2) : '0)
                    + (OUTQ_AW+2)'(2);
   assign req_stall = need > (OUTQ_AW+2)'(OUTQ_DEPTH);
   assign req_take  = req_valid & ~req_stall;
   assign pal_wr    = req_take & ~req_action & ({1'b0, req_palette_index} < PAL_LIMIT);
   assign pix_take  = req_take & req_action;
   assign new_level = quantize(req_blue, req_green, req_red);

   // A palette write lands at its own acceptance edge, so a pixel accepted later always
   // reads the updated entry; no forwarding is needed.
   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[req_palette_index[PAL_AW-1:0]] <= new_level;
      end
      if (pix_take) begin
         pal_rd_ff <= pal_mem[req_pixel_byte[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff    <= '0;
         pal_rd_vld_ff <= 1'b0;
         lvl0_ff       <= '0;
         lvl1_ff       <= '0;
      end else begin
         if (pal_wr) begin
            pal_vld_ff[req_palette_index[PAL_AW-1:0]] <= 1'b1;
            if (req_palette_index == 8'd0) begin
               lvl0_ff <= new_level;
            end
            if (req_palette_index == 8'd1) begin
               lvl1_ff <= new_level;
            end
         end
         if (pix_take) begin
            pal_rd_vld_ff <= pal_vld_ff[req_pixel_byte[PAL_AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= pix_take;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take) begin
         b_pix_ff     <= req_pixel_byte;
         b_inrange_ff <= {1'b0, req_pixel_byte} < PAL_LIMIT;
      end
   end

   // ---------------------------------------------------------------- packing stage
   always_comb begin
      lv       = (b_inrange_ff & pal_rd_vld_ff) ? pal_rd_ff : '0;
      col_next = {1'b0, column_ff} + (mode_ff ? 17'd8 : 17'd1);
      row_end  = col_next >= {1'b0, width_ff};
      img_end  = row_end & (({1'b0, src_row_ff} + 17'd1) >= {1'b0, height_ff});
      out_row  = height_ff - 16'd1 - src_row_ff;

      trans    = ~mode_ff & (lv == TRANSPARENT_CODE);
      seen_now = seen_ff | trans;
      gray_new = trans ? gray_ff
                       : gray_ff | ({6'd0, lv[1:0]} << {~column_ff[1:0], 1'b0});
      mask_new = trans ? mask_ff & ~(8'h80 >> column_ff[2:0]) : mask_ff;

      emit_gray = ~mode_ff & ((column_ff[1:0] == 2'd3) | row_end);
      emit_mask = ~mode_ff & ((column_ff[2:0] == 3'd7) | row_end);

      gray_res.plane      = PLANE_GRAY;
      gray_res.row        = out_row;
      gray_res.byte_index = column_ff[15:2];
      gray_res.value      = gray_new;
      gray_res.mask_used  = seen_now;
      gray_res.image_done = img_end;
      gray_res.last       = ~emit_mask;

      mask_res.plane      = PLANE_MASK;
      mask_res.row        = out_row;
      mask_res.byte_index = {1'b0, column_ff[15:3]};
      mask_res.value      = mask_new;
      mask_res.mask_used  = seen_now;
      mask_res.image_done = img_end;
      mask_res.last       = 1'b1;

      if (mode_ff) begin
         // One-bit data is inverted when entry 0 is darker than entry 1.
         res0.plane      = PLANE_ONE_BIT;
         res0.row        = out_row;
         res0.byte_index = {1'b0, column_ff[15:3]};
         res0.value      = (lvl0_ff < lvl1_ff) ? ~b_pix_ff : b_pix_ff;
         res0.mask_used  = seen_ff;
         res0.image_done = img_end;
         res0.last       = 1'b1;
         npush           = b_vld_ff ? 2'd1 : 2'd0;
      end else begin
         res0  = emit_gray ? gray_res : mask_res;
         npush = b_vld_ff ? (2'(emit_gray) + 2'(emit_mask)) : 2'd0;
      end
      res1 = mask_res;

      column_in  = column_ff;
      src_row_in = src_row_ff;
      gray_in    = gray_ff;
      mask_in    = mask_ff;
      seen_in    = seen_ff;
      if (b_vld_ff) begin
         if (!mode_ff) begin
            gray_in = emit_gray ? 8'h00 : gray_new;
            mask_in = emit_mask ? 8'hff : mask_new;
            seen_in = seen_now;
         end
         if (row_end) begin
            column_in = 16'd0;
            if (img_end) begin
               src_row_in = 16'd0;
               seen_in    = 1'b0;
            end else begin
               src_row_in = src_row_ff + 16'd1;
            end
         end else begin
            column_in = col_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= 16'd0;
         src_row_ff <= 16'd0;
         gray_ff    <= 8'h00;
         mask_ff    <= 8'hff;
         seen_ff    <= 1'b0;
      end else begin
         column_ff  <= column_in;
         src_row_ff <= src_row_in;
         gray_ff    <= gray_in;
         mask_ff    <= mask_in;
         seen_ff    <= seen_in;
      end
   end

   // ---------------------------------------------------------------- result queue
   assign rsp_valid      = count_ff != '0;
   assign pop            = rsp_valid & ~rsp_stall;
   assign rsp_plane      = outq[rd_ptr_ff].plane;
   assign rsp_row        = outq[rd_ptr_ff].row;
   assign rsp_byte_index = outq[rd_ptr_ff].byte_index;
   assign rsp_value      = outq[rd_ptr_ff].value;
   assign rsp_mask_used  = outq[rd_ptr_ff].mask_used;
   assign rsp_image_done = outq[rd_ptr_ff].image_done;
   assign rsp_last       = outq[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         outq[wr_ptr_ff] <= res0;
      end
      if (npush == 2'd2) begin
         outq[wr_ptr_ff + OUTQ_AW'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + OUTQ_AW'(npush);
         rd_ptr_ff <= rd_ptr_ff + OUTQ_AW'(pop);
         count_ff  <= count_ff + (OUTQ_AW+1)'(npush) - (OUTQ_AW+1)'(pop);
      end
   end

endmodule

@@ hw/rtl/p2g_checker.sv @@
// Port-level checker for palette_to_gray2_pixel_packer, attached by a bind statement.
// Depends on p2g_pkg.
module p2g_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_plane,
   input logic [15:0] rsp_row,
   input logic [13:0] rsp_byte_index,
   input logic [7:0]  rsp_value,
   input logic        rsp_last
);
   import p2g_pkg::*;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plane) && $stable(rsp_row)
         && $stable(rsp_byte_index) && $stable(rsp_value) && $stable(rsp_last))
      else $error("stalled result changed");

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Mask bytes and one-bit bytes always close the results of their item.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_plane == PLANE_MASK || rsp_plane == PLANE_ONE_BIT) |-> rsp_last)
      else $error("mask or one-bit result not marked last");

   // A gray byte that is not last is followed at once by the mask byte of the same row.
   a_gray_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_plane == PLANE_GRAY && !rsp_last |=>
         rsp_valid && rsp_plane == PLANE_MASK && rsp_row == $past(rsp_row))
      else $error("gray byte not followed by its mask byte");

endmodule

bind palette_to_gray2_pixel_packer p2g_checker u_p2g_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_plane      (rsp_plane),
   .rsp_row        (rsp_row),
   .rsp_byte_index (rsp_byte_index),
   .rsp_value      (rsp_value),
   .rsp_last       (rsp_last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for palette_to_gray2_pixel_packer: a typed directed table, then
// random images under changing geometry, checked against a behavioral packer model.
// Depends on p2g_pkg and the packer RTL.
module testbench;
   import p2g_pkg::*;

   localparam int  QUIET_LIMIT  = 4000;  // long receiver hold plus a config pause, many times over
   localparam int  RANDOM_ITEMS = 1750;
   localparam int  LONG_HOLD    = 400;
   localparam int  SETTLE       = 8;
   localparam bit  ACT_PALETTE  = 1'b0;
   localparam bit  ACT_PIXEL    = 1'b1;
   localparam int  LUMA_DARK    = 'h2a;
   localparam int  LUMA_MID     = 'h80;
   localparam int  LUMA_LIGHT   = 'hd4;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} stall_style_type;

   typedef struct {
      bit       action;
      bit [7:0] pal_idx;
      bit [7:0] blue;
      bit [7:0] green;
      bit [7:0] red;
      bit [7:0] pixel;
   } source_item_type;

   // Typed rows run under the reset geometry (one pixel per image), so each pixel
   // gives a gray byte then a mask byte, both at row 0, byte 0, with image_done set.
   typedef struct {
      source_item_type item;
      bit              typed;
      bit [7:0]        gray;
      bit [7:0]        mask;
      bit              mask_used;
   } directed_row_type;

   directed_row_type directed_rows [24] = '{
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 8'h00, 8'hff, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b1, 8'h00, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd1, 8'd255, 8'd255, 8'd255, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b1, 8'hc0, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd2, KEY_BLUE, KEY_GREEN, KEY_RED, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2}, 1'b1, 8'h00, 8'h7f, 1'b1},
      '{'{ACT_PALETTE, 8'd3, 8'd42, 8'd42, 8'd42, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3}, 1'b1, 8'h00, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd4, 8'd43, 8'd43, 8'd43, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4}, 1'b1, 8'h40, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd5, 8'd128, 8'd128, 8'd128, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd5}, 1'b1, 8'h40, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd6, 8'd129, 8'd129, 8'd129, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd6}, 1'b1, 8'h80, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd7, 8'd212, 8'd212, 8'd212, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7}, 1'b1, 8'h80, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd8, 8'd213, 8'd213, 8'd213, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8}, 1'b1, 8'hc0, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd9, 8'd64, 8'd128, 8'd129, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9}, 1'b1, 8'h40, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b1, 8'hc0, 8'hff, 1'b0},
      '{'{ACT_PALETTE, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0}, 1'b0, 8'h00, 8'h00, 1'b0},
      '{'{ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 8'h80, 8'hff, 1'b0}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   logic [7:0]          req_palette_index;
   logic [7:0]          req_blue;
   logic [7:0]          req_green;
   logic [7:0]          req_red;
   logic [7:0]          req_pixel_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_plane;
   logic [15:0]         rsp_row;
   logic [13:0]         rsp_byte_index;
   logic [7:0]          rsp_value;
   logic                rsp_mask_used;
   logic                rsp_image_done;
   logic                rsp_last;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   palette_to_gray2_pixel_packer dut (.*);

   // Packer model state and configuration.
   bit [2:0]     level_mem [256];
   bit           cfg_one_bit = 1'b0;
   bit [15:0]    cfg_width   = 16'd1;
   bit [15:0]    cfg_height  = 16'd1;
   int unsigned  column      = 0;
   int unsigned  src_row     = 0;
   bit [7:0]     gray_acc    = 8'h00;
   bit [7:0]     mask_acc    = 8'hff;
   bit           transp_seen = 1'b0;
   result_type   pending_bytes [$];

   int           burst_left = 0;
   int           mismatches = 0;
   bit           hold_now   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit [2:0] gray_level_of(bit [7:0] b, bit [7:0] g, bit [7:0] r);
      int luma;
      luma = (int'(b) + 6 * int'(g) + 3 * int'(r)) / 10;
      if (b == KEY_BLUE && g == KEY_GREEN && r == KEY_RED) return TRANSPARENT_CODE;
      if (luma <= LUMA_DARK) return 3'd0;
      if (luma <= LUMA_MID) return 3'd1;
      if (luma <= LUMA_LIGHT) return 3'd2;
      return 3'd3;
   endfunction

   // Advances the model by one accepted item and queues the bytes it produces.
   function automatic void pack_item(source_item_type it);
      result_type   outs [2];
      int           n;
      int           k;
      int unsigned  step;
      int unsigned  out_row;
      bit           row_end;
      bit           img_end;
      bit [2:0]     lv;
      bit [7:0]     inv;
      n = 0;
      if (it.action == ACT_PALETTE) begin
         if (it.pal_idx < PALETTE_ENTRIES) begin
            level_mem[it.pal_idx] = gray_level_of(it.blue, it.green, it.red);
         end
         return;
      end
      out_row = (32'(cfg_height) - 32'd1 - src_row) & 32'hffff;
      step    = cfg_one_bit ? 8 : 1;
      row_end = column + step >= cfg_width;
      img_end = row_end && (src_row + 1 >= cfg_height);
      if (cfg_one_bit) begin
         inv = (level_mem[0] < level_mem[1]) ? 8'hff : 8'h00;
         outs[0] = '{PLANE_ONE_BIT, 16'(out_row), 14'(column >> 3), it.pixel ^ inv,
                     1'b0, 1'b0, 1'b0};
         n = 1;
      end else begin
         lv = level_mem[it.pixel];
         if (lv == TRANSPARENT_CODE) begin
            transp_seen = 1'b1;
            mask_acc[7 - column % 8] = 1'b0;
         end else begin
            gray_acc = gray_acc | (8'(lv[1:0]) << (2 * (3 - column % 4)));
         end
         if (column % 4 == 3 || row_end) begin
            outs[n] = '{PLANE_GRAY, 16'(out_row), 14'(column >> 2), gray_acc, 1'b0, 1'b0, 1'b0};
            n++;
            gray_acc = 8'h00;
         end
         if (column % 8 == 7 || row_end) begin
            outs[n] = '{PLANE_MASK, 16'(out_row), 14'(column >> 3), mask_acc, 1'b0, 1'b0, 1'b0};
            n++;
            mask_acc = 8'hff;
         end
      end
      for (k = 0; k < n; k++) begin
         outs[k].mask_used  = transp_seen;
         outs[k].image_done = img_end;
         outs[k].last       = (k == n - 1);
         pending_bytes.push_back(outs[k]);
      end
      if (row_end) begin
         column = 0;
         if (img_end) begin
            src_row     = 0;
            transp_seen = 1'b0;
         end else begin
            src_row = (src_row + 1) & 32'hffff;
         end
      end else begin
         column = (column + step) & 32'hffff;
      end
   endfunction

   // Mostly pixels naming recently written entries; palette colors favor the key color
   // and gray shades sitting on the luma thresholds.
   function automatic source_item_type random_item(int idx_hi);
      source_item_type it;
      int              edge_pick;
      bit [7:0]        shade;
      it.action  = ($urandom_range(0, 99) < 25) ? ACT_PALETTE : ACT_PIXEL;
      it.pal_idx = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, idx_hi)) : 8'($urandom);
      it.pixel   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, idx_hi)) : 8'($urandom);
      case ($urandom_range(0, 9))
         0, 1: begin
            it.blue  = KEY_BLUE;
            it.green = KEY_GREEN;
            it.red   = KEY_RED;
         end
         2, 3: begin
            edge_pick = $urandom_range(0, 2);
            shade = 8'((edge_pick == 0) ? LUMA_DARK : (edge_pick == 1) ? LUMA_MID : LUMA_LIGHT)
                  + 8'($urandom_range(0, 1));
            it.blue  = shade;
            it.green = shade;
            it.red   = shade;
         end
         default: begin
            it.blue  = 8'($urandom);
            it.green = 8'($urandom);
            it.red   = 8'($urandom);
         end
      endcase
      return it;
   endfunction

   // Presents one item and returns at the edge that accepts it. Gaps between
   // bursts are inserted here.
   task automatic offer(source_item_type it);
      bit go;
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 32);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_palette_index <= it.pal_idx;
      req_blue          <= it.blue;
      req_green         <= it.green;
      req_red           <= it.red;
      req_pixel_byte    <= it.pixel;
      do begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
      end while (!go);
      pack_item(it);
   endtask

   // Stops offering until every queued byte has come out.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   task automatic write_reg(logic [1:0] regno, logic [31:0] data);
      bit ok;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(regno) << 2;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ok = csr_pready;
         @(posedge clock);
      end while (!ok);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (regno)
         REG_MODE:   cfg_one_bit = data[0];
         REG_WIDTH:  cfg_width   = data[15:0];
         REG_HEIGHT: cfg_height  = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One geometry setting. Position and accumulators carry over from the last one.
   task automatic run_phase(bit one_bit, bit [15:0] width, bit [15:0] height, int count,
                            int idx_hi, bit pause_mid, bit ask_hold);
      int i;
      drain();
      repeat (SETTLE) @(posedge clock);
      write_reg(REG_MODE, 32'(one_bit));
      write_reg(REG_WIDTH, 32'(width));
      write_reg(REG_HEIGHT, 32'(height));
      if (ask_hold) hold_now = 1'b1;
      for (i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) drain();
         offer(random_item(idx_hi));
      end
   endtask

   initial begin
      source_item_type it;
      int              sent;
      int              count;
      int              phase;
      bit              one_bit;
      bit              hold_asked;
      bit [15:0]       w;
      bit [15:0]       h;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= 1'b0;
      req_palette_index <= 8'h00;
      req_blue          <= 8'h00;
      req_green         <= 8'h00;
      req_red           <= 8'h00;
      req_pixel_byte    <= 8'h00;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         it = directed_rows[i].item;
         offer(it);
         if (directed_rows[i].typed) begin
            void'(pending_bytes.pop_back());
            void'(pending_bytes.pop_back());
            pending_bytes.push_back('{PLANE_GRAY, 16'd0, 14'd0, directed_rows[i].gray,
                                      directed_rows[i].mask_used, 1'b1, 1'b0});
            pending_bytes.push_back('{PLANE_MASK, 16'd0, 14'd0, directed_rows[i].mask,
                                      directed_rows[i].mask_used, 1'b1, 1'b1});
         end
      end

      // Scripted geometry: one-bit data, the largest image, then shrinking bounds under
      // a position already past them, which also wraps the output row.
      run_phase(1'b1, 16'd24, 16'd2, 20, 3, 1'b0, 1'b0);
      run_phase(1'b0, 16'hffff, 16'hffff, 40, 7, 1'b0, 1'b0);
      run_phase(1'b0, 16'd5, 16'hffff, 10, 7, 1'b0, 1'b0);
      run_phase(1'b0, 16'd1, 16'hffff, 20, 7, 1'b0, 1'b0);
      run_phase(1'b0, 16'd1, 16'd3, 6, 7, 1'b0, 1'b0);
      sent       = 96;
      phase      = 0;
      hold_asked = 1'b0;

      while (sent < RANDOM_ITEMS) begin
         one_bit = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0:       w = 16'hffff;
            1:       w = 16'd1;
            2, 3:    w = 16'($urandom_range(25, 300));
            default: w = 16'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 9))
            0:       h = 16'hffff;
            1:       h = 16'd1;
            2, 3:    h = 16'($urandom_range(7, 40));
            default: h = 16'($urandom_range(1, 6));
         endcase
         count = $urandom_range(30, 150);
         if (!hold_asked && sent >= 300) count = 200;
         run_phase(one_bit, w, h, count, $urandom_range(3, 31),
                   phase == 1 || $urandom_range(0, 9) == 0, !hold_asked && sent >= 300);
         if (sent >= 300) hold_asked = 1'b1;
         sent += count;
         phase++;
      end

      drain();
      repeat (4 * SETTLE) @(posedge clock);
      mismatches += pending_bytes.size();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Receiver: switches among random stall styles, and holds off once for a long stretch
   // when asked so that the block backs up into its input.
   initial begin
      stall_style_type style;
      int              left;
      int              hold_left;
      bit              held;
      bit              hold_seen;
      bit              stall_next;
      style     = FLOW_FREE;
      left      = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         hold_seen = hold_now;
         @(posedge clock);
         if (hold_seen && !held) begin
            held      = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (left == 0) begin
               style = stall_style_type'($urandom_range(0, 3));
               left  = $urandom_range(16, 160);
            end
            left--;
            case (style)
               FLOW_FREE:  stall_next = 1'b0;
               FLOW_LIGHT: stall_next = $urandom_range(0, 99) < 25;
               FLOW_HEAVY: stall_next = $urandom_range(0, 99) < 75;
               default:    stall_next = (left % 5 == 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   function automatic void flag_result(string what, result_type want, result_type got);
      if (mismatches < 10) begin
         $display("%0t: %s: expected plane %0d row %0d byte %0d value %02h used %0b done %0b last %0b",
                  $time, what, want.plane, want.row, want.byte_index, want.value,
                  want.mask_used, want.image_done, want.last);
         $display("%0t: %s:      got plane %0d row %0d byte %0d value %02h used %0b done %0b last %0b",
                  $time, what, got.plane, got.row, got.byte_index, got.value,
                  got.mask_used, got.image_done, got.last);
      end
      mismatches++;
   endfunction

   // Sampled mid-cycle: a transfer seen here completes at the next rising edge.
   int quiet = 0;
   always @(negedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_plane, rsp_row, rsp_byte_index, rsp_value,
                 rsp_mask_used, rsp_image_done, rsp_last};
         if (pending_bytes.size() == 0) begin
            flag_result("unexpected result", '0, got);
         end else begin
            want = pending_bytes.pop_front();
            if (got.plane !== want.plane || got.row !== want.row
                || got.byte_index !== want.byte_index || got.value !== want.value
                || got.mask_used !== want.mask_used || got.image_done !== want.image_done
                || got.last !== want.last) begin
               flag_result("result mismatch", want, got);
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

@@ sim.f @@
hw/rtl/p2g_pkg.sv
hw/rtl/palette_to_gray2_pixel_packer.sv
hw/rtl/p2g_checker.sv
tb/testbench.sv
